// ===== rtl/core/csvg_pkg.sv =====
`default_nettype none
package csvg_pkg;

	localparam int LOD_W   = 9;
	localparam int RAD_W   = 20;
	localparam int CFG_W   = 20;
	localparam int POS_W   = 22;
	localparam int IDX_W   = 19;
	localparam int MAG_W   = 9;
	localparam int S_W     = 20;
	localparam int Q_W     = 26;
	localparam int SQR_W   = 29;
	localparam int PROD_W  = 29;
	localparam int NUM_W   = 46;
	localparam int QUO_W   = 21;
	localparam int DREM_W  = 26;
	localparam int GRID_DEF = 256;
	localparam int LOD_MAX  = 511;

	localparam logic [LOD_W-1:0] LOD_MIN = 9'd2;
	localparam logic [LOD_W-1:0] LOD_RST = 9'd16;
	localparam logic [RAD_W-1:0] RAD_RST = 20'd196608;
	localparam logic [QUO_W-1:0] POS_LIMIT = 21'd1048576;
	localparam logic [2:0] FACE_LAST = 3'd5;

	// square root of S * 2^32, two radicand bits per iteration
	localparam int SQ_ITERS  = 26;
	localparam int SQ_PER    = 3;
	localparam int SQ_STAGES = (SQ_ITERS + SQ_PER - 1) / SQ_PER;
	// quotient stays below 2^21, one bit per iteration
	localparam int DV_ITERS  = 21;
	localparam int DV_PER    = 3;
	localparam int DV_STAGES = (DV_ITERS + DV_PER - 1) / DV_PER;
	localparam int NSTG      = SQ_STAGES + DV_STAGES + 4;

	typedef enum logic {REG_LOD = 1'b0, REG_RADIUS = 1'b1} reg_idx_t;

	typedef enum logic [2:0] {K_IN, K_MUL, K_SQRT, K_DINIT, K_DIV, K_OUT} stage_kind_t;

	// which of d, u, v feeds a component
	typedef enum logic [1:0] {SRC_D, SRC_U, SRC_V} src_t;

	// w = d*F + u*A + v*B, worked out per face; faces 6 and 7 are off-table
	localparam src_t FACE_SRC [8][3] = '{
		'{SRC_V, SRC_U, SRC_D},
		'{SRC_D, SRC_V, SRC_U},
		'{SRC_D, SRC_V, SRC_U},
		'{SRC_U, SRC_D, SRC_V},
		'{SRC_U, SRC_D, SRC_V},
		'{SRC_V, SRC_U, SRC_D},
		'{SRC_D, SRC_D, SRC_D},
		'{SRC_D, SRC_D, SRC_D}
	};
	localparam logic FACE_NEG [8][3] = '{
		'{1'b1, 1'b1, 1'b1},
		'{1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b1, 1'b1},
		'{1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0}
	};

	typedef struct packed {
		logic [2:0]                   face;
		logic [7:0]                   row;
		logic [7:0]                   col;
		logic [LOD_W-1:0]             lod;
		logic [2*LOD_W-1:0]           ll;
		logic [LOD_W+7:0]             rowl;
		logic                         bad;
		logic                         quad;
		logic [2:0]                   neg;
		logic [2:0][MAG_W-1:0]        mag;
		logic [IDX_W-1:0]             idx;
		logic [S_W-1:0]               s;
		logic [2:0][PROD_W-1:0]       prod;
		logic [Q_W-1:0]               root;
		logic [SQR_W-1:0]             sqrem;
		logic [2:0][DREM_W-1:0]       drem;
		logic [2:0][QUO_W-1:0]        nlo;
		logic [2:0][QUO_W-1:0]        quo;
		logic [2:0][POS_W-1:0]        pos;
		logic [IDX_W-1:0]             below;
		logic [IDX_W-1:0]             diag;
		logic [IDX_W-1:0]             right;
	} pay_t;

endpackage
`default_nettype wire

// ===== rtl/core/csvg_stage.sv =====
`default_nettype none
module csvg_stage import csvg_pkg::*; #(
	parameter stage_kind_t KIND = K_IN,
	parameter int BASE = 0,
	parameter int MAX_GRID = GRID_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [LOD_W-1:0] lod,
	input  wire logic [RAD_W-1:0] radius,
	input  wire logic             in_valid,
	input  wire pay_t             in_pay,
	output logic                  in_ready,
	output logic                  out_valid,
	output pay_t                  out_pay,
	input  wire logic             out_adv
);

	localparam logic [LOD_W-1:0] GRID_CAP =
		LOD_W'((MAX_GRID > LOD_MAX) ? LOD_MAX : MAX_GRID);

	logic                      valid_q;
	pay_t                      pay_q;
	pay_t                      nxt;
	logic [LOD_W-1:0]          l_eff;
	logic [LOD_W-1:0]          d;
	logic signed [LOD_W:0]     u_s;
	logic signed [LOD_W:0]     v_s;
	logic [MAG_W-1:0]          umag;
	logic [MAG_W-1:0]          vmag;
	logic [2:0]                fi;
	logic                      sn;
	logic [20:0]               idx_w;
	logic [NUM_W-1:0]          num;
	logic [S_W+31:0]           rad_sh;
	logic [SQR_W-1:0]          trial;
	logic [DREM_W:0]           r;
	logic [QUO_W-1:0]          nsh;

	always_comb begin
		nxt    = in_pay;
		l_eff  = in_pay.lod;
		d      = '0;
		u_s    = '0;
		v_s    = '0;
		umag   = '0;
		vmag   = '0;
		fi     = '0;
		sn     = 1'b0;
		idx_w  = '0;
		num    = '0;
		rad_sh = '0;
		trial  = '0;
		r      = '0;
		nsh    = '0;
		unique case (KIND)
			K_IN: begin
				if (lod < LOD_MIN) begin
					l_eff = LOD_MIN;
				end else if (lod > GRID_CAP) begin
					l_eff = GRID_CAP;
				end else begin
					l_eff = lod;
				end
				d    = l_eff - 1'b1;
				u_s  = signed'({1'b0, in_pay.row, 1'b0}) - signed'({1'b0, d});
				v_s  = signed'({1'b0, in_pay.col, 1'b0}) - signed'({1'b0, d});
				umag = u_s[LOD_W] ? MAG_W'(-u_s) : u_s[MAG_W-1:0];
				vmag = v_s[LOD_W] ? MAG_W'(-v_s) : v_s[MAG_W-1:0];
				fi   = (in_pay.face > FACE_LAST) ? 3'd0 : in_pay.face;
				for (int c = 0; c < 3; c++) begin
					unique case (FACE_SRC[fi][c])
						SRC_D: begin nxt.mag[c] = d;    sn = 1'b0;       end
						SRC_U: begin nxt.mag[c] = umag; sn = u_s[LOD_W]; end
						SRC_V: begin nxt.mag[c] = vmag; sn = v_s[LOD_W]; end
						default: begin nxt.mag[c] = '0; sn = 1'b0; end
					endcase
					nxt.neg[c] = FACE_NEG[fi][c] ^ sn;
				end
				nxt.lod  = l_eff;
				nxt.ll   = l_eff * l_eff;
				nxt.rowl = in_pay.row * l_eff;
				nxt.bad  = (in_pay.face > FACE_LAST) || ({1'b0, in_pay.row} >= l_eff)
					|| ({1'b0, in_pay.col} >= l_eff);
				nxt.quad = !nxt.bad && ({1'b0, in_pay.row} < d) && ({1'b0, in_pay.col} < d);
			end
			K_MUL: begin
				idx_w = 21'(in_pay.face) * 21'(in_pay.ll) + 21'(in_pay.rowl)
					+ 21'(in_pay.col);
				nxt.idx = idx_w[IDX_W-1:0];
				nxt.s = S_W'(in_pay.mag[0]) * S_W'(in_pay.mag[0])
					+ S_W'(in_pay.mag[1]) * S_W'(in_pay.mag[1])
					+ S_W'(in_pay.mag[2]) * S_W'(in_pay.mag[2]);
				for (int c = 0; c < 3; c++) begin
					nxt.prod[c] = PROD_W'(radius) * PROD_W'(in_pay.mag[c]);
				end
				nxt.root  = '0;
				nxt.sqrem = '0;
			end
			K_SQRT: begin
				for (int i = 0; i < SQ_PER; i++) begin
					if (BASE + i < SQ_ITERS) begin
						rad_sh    = {in_pay.s, 32'b0} << (2 * (BASE + i));
						nxt.sqrem = {nxt.sqrem[SQR_W-3:0], rad_sh[S_W+31 -: 2]};
						trial     = {1'b0, nxt.root, 2'b01};
						if (nxt.sqrem >= trial) begin
							nxt.sqrem = nxt.sqrem - trial;
							nxt.root  = {nxt.root[Q_W-2:0], 1'b1};
						end else begin
							nxt.root  = {nxt.root[Q_W-2:0], 1'b0};
						end
					end
				end
			end
			K_DINIT: begin
				for (int c = 0; c < 3; c++) begin
					num = {1'b0, in_pay.prod[c], 16'b0} + NUM_W'(in_pay.root >> 1);
					nxt.drem[c] = DREM_W'(num[NUM_W-1:QUO_W]);
					nxt.nlo[c]  = num[QUO_W-1:0];
					nxt.quo[c]  = '0;
				end
			end
			K_DIV: begin
				for (int c = 0; c < 3; c++) begin
					for (int i = 0; i < DV_PER; i++) begin
						if (BASE + i < DV_ITERS) begin
							nsh = in_pay.nlo[c] << (BASE + i);
							r   = {nxt.drem[c], nsh[QUO_W-1]};
							if (r >= {1'b0, in_pay.root}) begin
								r = r - {1'b0, in_pay.root};
								nxt.quo[c] = {nxt.quo[c][QUO_W-2:0], 1'b1};
							end else begin
								nxt.quo[c] = {nxt.quo[c][QUO_W-2:0], 1'b0};
							end
							nxt.drem[c] = r[DREM_W-1:0];
						end
					end
				end
			end
			K_OUT: begin
				for (int c = 0; c < 3; c++) begin
					nsh = (in_pay.quo[c] > POS_LIMIT) ? POS_LIMIT : in_pay.quo[c];
					if (in_pay.bad) begin
						nxt.pos[c] = '0;
					end else if (in_pay.neg[c]) begin
						nxt.pos[c] = -{1'b0, nsh};
					end else begin
						nxt.pos[c] = {1'b0, nsh};
					end
				end
				nxt.idx   = in_pay.bad ? '0 : in_pay.idx;
				nxt.below = in_pay.quad ? in_pay.idx + IDX_W'(in_pay.lod) : '0;
				nxt.diag  = in_pay.quad ? in_pay.idx + IDX_W'(in_pay.lod) + 1'b1 : '0;
				nxt.right = in_pay.quad ? in_pay.idx + 1'b1 : '0;
			end
			default: nxt = in_pay;
		endcase
	end

	assign in_ready  = !valid_q || out_adv;
	assign out_valid = valid_q;
	assign out_pay   = pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pay_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cube_sphere_vertex_generator.sv =====
// Cube-sphere vertex generator.
// Input stream: one request per grid point (face, row, col). Output stream:
// one result per request with the Q5.16 position on the sphere, the vertex
// index and the three other corner indices of the quad the point opens.
// Points off the grid or on an unknown face come out with bad_point set and
// all other fields zero.
// Stages in order: input capture, index and square products, 9 square-root
// stages (up to 3 radicand digit pairs each), a numerator stage, 7 divider
// stages (3 quotient bits each for all three axes) and the output format
// stage. Throughput is one vertex per cycle while m_tready is high. Each
// stage holds its own valid bit and takes a new request when it is empty or
// its successor moves, so bubbles are squeezed out while the receiver
// stalls; a full pipe holds everything. Reset clears all valid bits and sets
// lod to 16 and radius to 3.0. lod and radius are written through the cfg
// port; the user must do so only while the pipe is empty (not enforced).
`default_nettype none
module cube_sphere_vertex_generator import csvg_pkg::*; #(
	parameter int MAX_GRID = GRID_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [23:0]      s_tdata,   // face[2:0], row[10:3], col[18:11]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// pos_x[21:0], pos_y[43:22], pos_z[65:44], vertex_index[84:66],
	// below_index[103:85], diag_index[122:104], right_index[141:123]
	output logic [143:0]          m_tdata,
	output logic [1:0]            m_tuser    // has_quad[0], bad_point[1]
);

	logic [LOD_W-1:0] lod_q;
	logic [RAD_W-1:0] radius_q;
	logic             vld [NSTG+1];
	logic             rdy [NSTG+1];
	pay_t             pay [NSTG+1];
	pay_t             last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_q    <= LOD_RST;
			radius_q <= RAD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOD:    lod_q    <= cfg_wdata[LOD_W-1:0];
				REG_RADIUS: radius_q <= cfg_wdata[RAD_W-1:0];
				default:    lod_q    <= lod_q;
			endcase
		end
	end

	always_comb begin
		pay[0]      = '0;
		pay[0].face = s_tdata[2:0];
		pay[0].row  = s_tdata[10:3];
		pay[0].col  = s_tdata[18:11];
	end
	assign vld[0]    = s_tvalid;
	assign s_tready  = rdy[0];
	assign rdy[NSTG] = m_tready;

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		localparam stage_kind_t KIND =
			(k == 0) ? K_IN :
			(k == 1) ? K_MUL :
			(k < SQ_STAGES + 2) ? K_SQRT :
			(k == SQ_STAGES + 2) ? K_DINIT :
			(k < NSTG - 1) ? K_DIV : K_OUT;
		localparam int BASE =
			(KIND == K_SQRT) ? (k - 2) * SQ_PER :
			(KIND == K_DIV) ? (k - SQ_STAGES - 3) * DV_PER : 0;
		csvg_stage #(
			.KIND(KIND),
			.BASE(BASE),
			.MAX_GRID(MAX_GRID)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.lod      (lod_q),
			.radius   (radius_q),
			.in_valid (vld[k]),
			.in_pay   (pay[k]),
			.in_ready (rdy[k]),
			.out_valid(vld[k+1]),
			.out_pay  (pay[k+1]),
			.out_adv  (rdy[k+1])
		);
	end

	assign last     = pay[NSTG];
	assign m_tvalid = vld[NSTG];
	assign m_tdata  = {2'b00, last.right, last.diag, last.below, last.idx,
		last.pos[2], last.pos[1], last.pos[0]};
	assign m_tuser  = {last.bad, last.quad};

	// input side only backs up when the result register is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled with output free");

	// rejected points carry nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
		else $error("bad point with nonzero fields");

	// quad corners follow the vertex index
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		(m_tdata[141:123] == m_tdata[84:66] + 19'd1 &&
		 m_tdata[122:104] == m_tdata[103:85] + 19'd1))
		else $error("quad indices inconsistent");

	// pos_x stays within the saturation limit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[21:0]) <= 22'sd1048576 &&
		 $signed(m_tdata[21:0]) >= -22'sd1048576))
		else $error("pos_x out of range");

endmodule
`default_nettype wire

// ===== test/cube_sphere_vertex_generator_tb.sv =====
`default_nettype none
module cube_sphere_vertex_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csvg_pkg::*;

	typedef struct {
		logic [POS_W-1:0] px, py, pz;
		logic [IDX_W-1:0] vidx, below, diag, right;
		logic has_quad, bad;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [1:0] m_tuser;

	cube_sphere_vertex_generator dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int unsigned lod_reg = 16;
	int unsigned radius_reg = 196608;
	vertex_t pending_vertices[$];
	int errors = 0;
	int unsigned cycles = 0;
	int hold_cycles = 0;
	int rx_wait = 0;
	int rx_draw;
	localparam int CYCLE_LIMIT = 600000;

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic vertex_t place_vertex(int unsigned face, int unsigned row,
			int unsigned col);
		vertex_t e;
		int unsigned lv;
		longint f[3], a[3], b[3], w[3], d, u, v;
		longint unsigned s, q, mag, p, idx;
		logic [POS_W-1:0] pc[3];
		e = '{default: '0};
		lv = lod_reg < 2 ? 2 : (lod_reg > 256 ? 256 : lod_reg);
		if (face > 5 || row >= lv || col >= lv) begin
			e.bad = 1'b1;
			return e;
		end
		f = '{0, 0, 0};
		case (face)
			0: f[2] = -1;
			1: f[0] = -1;
			2: f[0] = 1;
			3: f[1] = 1;
			4: f[1] = -1;
			default: f[2] = 1;
		endcase
		a[0] = f[1]; a[1] = f[2]; a[2] = f[0];
		b[0] = f[1] * a[2] - f[2] * a[1];
		b[1] = f[2] * a[0] - f[0] * a[2];
		b[2] = f[0] * a[1] - f[1] * a[0];
		d = lv - 1;
		u = 2 * row - d;
		v = 2 * col - d;
		s = 0;
		for (int c = 0; c < 3; c++) begin
			w[c] = d * f[c] + u * a[c] + v * b[c];
			s += w[c] * w[c];
		end
		q = root64(s << 32);
		for (int c = 0; c < 3; c++) begin
			mag = w[c] < 0 ? -w[c] : w[c];
			p = ((longint'(radius_reg) * mag << 16) + q / 2) / q;
			if (p > 1048576) p = 1048576;
			pc[c] = w[c] < 0 ? POS_W'(-p) : POS_W'(p);
		end
		e.px = pc[0]; e.py = pc[1]; e.pz = pc[2];
		idx = face * lv * lv + row * lv + col;
		e.vidx = idx[IDX_W-1:0];
		if (row < lv - 1 && col < lv - 1) begin
			e.has_quad = 1'b1;
			e.below = IDX_W'(idx + lv);
			e.diag = IDX_W'(idx + lv + 1);
			e.right = IDX_W'(idx + 1);
		end
		return e;
	endfunction

	// valid stays high on return; the next gap or write_reg drops it
	task automatic send_point(int unsigned face, int unsigned row, int unsigned col);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, col[7:0], row[7:0], face[2:0]};
		pending_vertices.insert(pending_vertices.size(), place_vertex(face, row, col));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LOD) lod_reg = val & 9'h1FF;
		else radius_reg = val & 20'hFFFFF;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random wait after each accepted vertex, or a long hold when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= 1'b0;
		end else if (m_tready && m_tvalid) begin
			rx_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			rx_wait <= rx_draw > 0 ? rx_draw - 1 : 0;
			m_tready <= (rx_draw == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		vertex_t e, g;
		if (arst_n && m_tvalid && m_tready) begin
			g.px = m_tdata[21:0]; g.py = m_tdata[43:22]; g.pz = m_tdata[65:44];
			g.vidx = m_tdata[84:66]; g.below = m_tdata[103:85];
			g.diag = m_tdata[122:104]; g.right = m_tdata[141:123];
			g.has_quad = m_tuser[0]; g.bad = m_tuser[1];
			if (pending_vertices.size() == 0) begin
				$error("unexpected vertex");
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (g.px != e.px) begin $error("pos_x exp %h got %h", e.px, g.px); errors++; end
				if (g.py != e.py) begin $error("pos_y exp %h got %h", e.py, g.py); errors++; end
				if (g.pz != e.pz) begin $error("pos_z exp %h got %h", e.pz, g.pz); errors++; end
				if (g.vidx != e.vidx) begin
					$error("vertex_index exp %0d got %0d", e.vidx, g.vidx); errors++;
				end
				if (g.below != e.below) begin
					$error("below_index exp %0d got %0d", e.below, g.below); errors++;
				end
				if (g.diag != e.diag) begin
					$error("diag_index exp %0d got %0d", e.diag, g.diag); errors++;
				end
				if (g.right != e.right) begin
					$error("right_index exp %0d got %0d", e.right, g.right); errors++;
				end
				if (g.has_quad != e.has_quad) begin
					$error("has_quad exp %0d got %0d", e.has_quad, g.has_quad); errors++;
				end
				if (g.bad != e.bad) begin
					$error("bad_point exp %0d got %0d", e.bad, g.bad); errors++;
				end
			end
		end
	end

	task automatic test_directed();
		int unsigned ext[3];
		for (int f = 0; f < 8; f++) send_point(f, f, 15 - f);
		ext = '{0, 15, 14};
		foreach (ext[i]) send_point(5, ext[i], 0);
		send_point(0, 255, 255);
		send_point(1, 16, 3);
		send_point(2, 3, 16);
		send_point(3, 170, 85);
		send_point(4, 85, 170);
		send_point(3, 7, 8);
	endtask

	task automatic random_points(int n);
		int unsigned lv, f, r, c;
		lv = lod_reg < 2 ? 2 : (lod_reg > 256 ? 256 : lod_reg);
		for (int i = 0; i < n; i++) begin
			f = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 5);
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom_range(0, 255);
				c = $urandom_range(0, 255);
			end else begin
				r = $urandom_range(0, 4) == 0 ? lv - 1 : $urandom_range(0, lv - 1);
				c = $urandom_range(0, 4) == 0 ? lv - 1 : $urandom_range(0, lv - 1);
			end
			send_point(f, r, c);
		end
	endtask

	task automatic test_lod_settings();
		int unsigned lods[6];
		lods = '{2, 256, 511, 0, 1, 5};
		foreach (lods[i]) begin
			write_reg(REG_LOD, lods[i]);
			send_point(0, 0, 0);
			send_point(5, 255, 255);
			random_points(60);
		end
	endtask

	task automatic test_radius_settings();
		int unsigned rads[4];
		rads = '{0, 1048575, 1, 65536};
		write_reg(REG_LOD, 9);
		foreach (rads[i]) begin
			write_reg(REG_RADIUS, rads[i]);
			random_points(60);
		end
	endtask

	// receiver holds off while the sender keeps offering, filling the pipe
	task automatic test_backpressure();
		write_reg(REG_LOD, 200);
		write_reg(REG_RADIUS, $urandom_range(0, 1048575));
		hold_cycles = 300;
		for (int i = 0; i < 60; i++) begin
			s_tvalid <= 1'b1;
			s_tdata <= {5'd0, 8'(i), 8'(i * 3), 3'(i % 6)};
			pending_vertices.insert(pending_vertices.size(),
				place_vertex(i % 6, (i * 3) & 255, i));
			do @(posedge clk); while (!s_tready);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic test_random();
		for (int k = 0; k < 8; k++) begin
			write_reg(REG_LOD, $urandom_range(2, 256));
			write_reg(REG_RADIUS, $urandom_range(0, 1048575));
			random_points(150);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lod_settings();
		test_radius_settings();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/csvg_pkg.sv
rtl/core/csvg_stage.sv
rtl/core/cube_sphere_vertex_generator.sv
test/cube_sphere_vertex_generator_tb.sv
